### hdl/owbm_pkg.sv
package owbm_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int TIME_W      = 10;
    localparam int NUM_REGS    = 8;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
    localparam logic [2:0] REG_ONE_LOW       = 3'd3;
    localparam logic [2:0] REG_ONE_RELEASE   = 3'd4;
    localparam logic [2:0] REG_ZERO_LOW      = 3'd5;
    localparam logic [2:0] REG_READ_LOW      = 3'd6;
    localparam logic [2:0] REG_READ_RECOVER  = 3'd7;

    localparam logic [TIME_W-1:0] RESET_LOW_INIT     = 10'd50;
    localparam logic [TIME_W-1:0] PRESENCE_WAIT_INIT = 10'd50;
    localparam logic [TIME_W-1:0] RESET_RECOVER_INIT = 10'd50;
    localparam logic [TIME_W-1:0] ONE_LOW_INIT       = 10'd1;
    localparam logic [TIME_W-1:0] ONE_RELEASE_INIT   = 10'd50;
    localparam logic [TIME_W-1:0] ZERO_LOW_INIT      = 10'd50;
    localparam logic [TIME_W-1:0] READ_LOW_INIT      = 10'd2;
    localparam logic [TIME_W-1:0] READ_RECOVER_INIT  = 10'd60;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] write_byte;
        logic       line_in;
    } owbm_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
    } owbm_out_t;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_wait_time;
        logic [TIME_W-1:0] reset_recovery_time;
        logic [TIME_W-1:0] one_low_time;
        logic [TIME_W-1:0] one_release_time;
        logic [TIME_W-1:0] zero_low_time;
        logic [TIME_W-1:0] read_low_time;
        logic [TIME_W-1:0] read_recovery_time;
    } owbm_cfg_t;

endpackage

### hdl/owbm_cfg.sv
module owbm_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owbm_pkg::TIME_W-1:0]      cfg_data,
    output owbm_pkg::owbm_cfg_t              cfg
);

    owbm_pkg::owbm_cfg_t cfg_reg;
    owbm_pkg::owbm_cfg_t cfg_next;
    logic                write_en;

    assign cfg_ready = 1'b1;
    assign write_en  = cfg_valid && cfg_ready
                       && (cfg_index < owbm_pkg::CFG_INDEX_W'(owbm_pkg::NUM_REGS));
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (cfg_index[2:0])
                owbm_pkg::REG_RESET_LOW:     cfg_next.reset_low_time      = cfg_data;
                owbm_pkg::REG_PRESENCE_WAIT: cfg_next.presence_wait_time  = cfg_data;
                owbm_pkg::REG_RESET_RECOVER: cfg_next.reset_recovery_time = cfg_data;
                owbm_pkg::REG_ONE_LOW:       cfg_next.one_low_time        = cfg_data;
                owbm_pkg::REG_ONE_RELEASE:   cfg_next.one_release_time    = cfg_data;
                owbm_pkg::REG_ZERO_LOW:      cfg_next.zero_low_time       = cfg_data;
                owbm_pkg::REG_READ_LOW:      cfg_next.read_low_time       = cfg_data;
                owbm_pkg::REG_READ_RECOVER:  cfg_next.read_recovery_time  = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time      <= owbm_pkg::RESET_LOW_INIT;
            cfg_reg.presence_wait_time  <= owbm_pkg::PRESENCE_WAIT_INIT;
            cfg_reg.reset_recovery_time <= owbm_pkg::RESET_RECOVER_INIT;
            cfg_reg.one_low_time        <= owbm_pkg::ONE_LOW_INIT;
            cfg_reg.one_release_time    <= owbm_pkg::ONE_RELEASE_INIT;
            cfg_reg.zero_low_time       <= owbm_pkg::ZERO_LOW_INIT;
            cfg_reg.read_low_time       <= owbm_pkg::READ_LOW_INIT;
            cfg_reg.read_recovery_time  <= owbm_pkg::READ_RECOVER_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/owbm_core.sv
module owbm_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  owbm_pkg::owbm_in_t   item,
    input  owbm_pkg::owbm_cfg_t  cfg,
    output owbm_pkg::owbm_out_t  result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_W_LOW,
        PH_W_REL,
        PH_R_LOW,
        PH_R_REC
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [owbm_pkg::TIME_W-1:0] tick_count_reg, tick_count_next;
    logic [2:0]                  bit_index_reg, bit_index_next;
    logic [7:0]                  shift_byte_reg, shift_byte_next;
    logic                        presence_reg, presence_next;
    logic [7:0]                  last_read_reg, last_read_next;

    phase_t                      ph;
    logic [7:0]                  sb;
    logic [owbm_pkg::TIME_W-1:0] tc;
    logic [2:0]                  bi;
    logic [owbm_pkg::TIME_W-1:0] len;
    logic [owbm_pkg::TIME_W:0]   tc_inc;
    logic                        cur_bit;
    logic                        finish;
    logic                        drive;
    logic                        busy;

    always_comb
    begin
        ph             = phase_reg;
        sb             = shift_byte_reg;
        tc             = tick_count_reg;
        bi             = bit_index_reg;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        finish         = 1'b0;
        drive          = 1'b0;
        busy           = 1'b0;
        len            = '0;
        cur_bit        = 1'b0;
        tc_inc         = '0;

        if ((phase_reg == PH_IDLE) && (item.op != owbm_pkg::OP_NONE))
        begin
            tc = '0;
            bi = '0;
            unique case (item.op)
                owbm_pkg::OP_RESET:
                begin
                    ph = PH_RST_LOW;
                end
                owbm_pkg::OP_WRITE:
                begin
                    sb = item.write_byte;
                    ph = PH_W_LOW;
                end
                default:
                begin
                    sb = '0;
                    ph = PH_R_LOW;
                end
            endcase
        end

        if (ph != PH_IDLE)
        begin
            cur_bit = sb[0];
            busy    = 1'b1;
            drive   = (ph == PH_RST_LOW) || (ph == PH_W_LOW) || (ph == PH_R_LOW);

            unique case (ph)
                PH_RST_LOW:  len = cfg.reset_low_time;
                PH_RST_WAIT: len = cfg.presence_wait_time;
                PH_RST_REC:  len = cfg.reset_recovery_time;
                PH_W_LOW:    len = cur_bit ? cfg.one_low_time : cfg.zero_low_time;
                PH_W_REL:    len = cfg.one_release_time;
                PH_R_LOW:    len = cfg.read_low_time;
                default:     len = cfg.read_recovery_time;
            endcase

            if (tc == '0)
            begin
                if (ph == PH_RST_REC)
                begin
                    presence_next = !item.line_in;
                end
                else if (ph == PH_R_REC)
                begin
                    sb = sb | (8'(item.line_in) << bi);
                end
            end

            tc_inc = {1'b0, tc} + 11'd1;
            if (tc_inc < {1'b0, len})
            begin
                tc = tc_inc[owbm_pkg::TIME_W-1:0];
            end
            else
            begin
                tc = '0;
                unique case (ph)
                    PH_RST_LOW:  ph = PH_RST_WAIT;
                    PH_RST_WAIT: ph = PH_RST_REC;
                    PH_RST_REC:  finish = 1'b1;
                    PH_W_LOW, PH_W_REL:
                    begin
                        if ((ph == PH_W_LOW) && cur_bit)
                        begin
                            ph = PH_W_REL;
                        end
                        else
                        begin
                            sb = sb >> 1;
                            if (bi == 3'd7)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                bi = bi + 3'd1;
                                ph = PH_W_LOW;
                            end
                        end
                    end
                    PH_R_LOW:    ph = PH_R_REC;
                    default:
                    begin
                        if (bi == 3'd7)
                        begin
                            last_read_next = sb;
                            finish         = 1'b1;
                        end
                        else
                        begin
                            bi = bi + 3'd1;
                            ph = PH_R_LOW;
                        end
                    end
                endcase
            end

            if (finish)
            begin
                ph = PH_IDLE;
                bi = '0;
            end
        end

        phase_next      = ph;
        shift_byte_next = sb;
        tick_count_next = tc;
        bit_index_next  = bi;

        result.drive_low = drive;
        result.busy_res  = busy;
        result.done_res  = finish;
        result.presence  = presence_next;
        result.read_byte = last_read_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            presence_reg   <= 1'b0;
            last_read_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            presence_reg   <= presence_next;
            last_read_reg  <= last_read_next;
        end
    end

endmodule

### hdl/onewire_bus_master.sv
// One-wire bus master: each input transaction is one timing tick and yields one result.
// A tick is captured in the input register; its result is computed from it and
// registered in the output register, where it is held while out_stall is high.
// Throughput: one tick per cycle while out_stall does not hold the output register.
// Reset (rst_n, asynchronous, active low) idles the bus, clears the valid flags and
// the core state and restores the default timing registers.
module onewire_bus_master
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  owbm_pkg::owbm_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output owbm_pkg::owbm_out_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owbm_pkg::TIME_W-1:0]      cfg_data
);

    logic                in_valid_reg;
    owbm_pkg::owbm_in_t  in_item_reg;
    logic                out_valid_reg;
    owbm_pkg::owbm_out_t out_item_reg;
    owbm_pkg::owbm_cfg_t cfg;
    owbm_pkg::owbm_out_t step_result;
    logic                advance;
    logic                in_take;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    owbm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

endmodule
